// File: design/floor_cast_texel_address_defines.svh
// Assertion macros shared by the floor cast design.
`ifndef FLOOR_CAST_TEXEL_ADDRESS_DEFINES_SVH
`define FLOOR_CAST_TEXEL_ADDRESS_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FCTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FCTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/fcta_pkg.sv
// ----------------------------------------------------------------------------
// Floor cast package
// Shared status codes, configuration register indexes and result record of the floor cast pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package fcta_pkg;

  // Result status codes.
  localparam logic [2:0] StTexel   = 3'd0;
  localparam logic [2:0] StHorizon = 3'd1;
  localparam logic [2:0] StOutside = 3'd2;
  localparam logic [2:0] StBadTex  = 3'd3;
  localparam logic [2:0] StWritten = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] RegPosX   = 3'd0;
  localparam logic [2:0] RegPosY   = 3'd1;
  localparam logic [2:0] RegDirX   = 3'd2;
  localparam logic [2:0] RegDirY   = 3'd3;
  localparam logic [2:0] RegPlaneX = 3'd4;
  localparam logic [2:0] RegPlaneY = 3'd5;
  localparam logic [2:0] RegCols   = 3'd6;
  localparam logic [2:0] RegRows   = 3'd7;

  // One finished result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [3:0]  texture_number;
    logic [5:0]  texel_u;
    logic [5:0]  texel_v;
    logic [11:0] texel_address;
  } result_t;

endpackage
`default_nettype wire

// File: design/floor_cast_texel_address.sv
// ----------------------------------------------------------------------------
// Floor cast texel address
// Maps screen pixels below the horizon to floor texels of a cell map.
// ----------------------------------------------------------------------------
// One beat enters per clock while the input is not stalled, and results
// leave in order. A result passes two input stages, 49 divider stages
// (operand capture plus one per quotient bit of the 48-bit numerator),
// the map read stage and the output register. The whole pipeline
// advances only when the output register is empty or being taken, so a
// stall on the result side holds every stage and stalls the input in the
// same cycle. Map writes flow through the same pipeline and update the
// map in their own stage, so later pixels see them.
`default_nettype none
`include "floor_cast_texel_address_defines.svh"
module floor_cast_texel_address #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  parameter int unsigned MAP_SIZE      = 64,
  parameter int unsigned TEX_SIZE      = 64,
  parameter int unsigned NUM_TEXTURES  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [9:0]  screen_x_i,
  input  wire logic [8:0]  screen_y_i,
  input  wire logic [5:0]  cell_col_i,
  input  wire logic [5:0]  cell_row_i,
  input  wire logic [3:0]  cell_texture_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [9:0]       pixel_x_o,
  output logic [8:0]       pixel_y_o,
  output logic [3:0]       texture_number_o,
  output logic [5:0]       texel_u_o,
  output logic [5:0]       texel_v_o,
  output logic [11:0]      texel_address_o
);

  localparam int unsigned HalfH = SCREEN_HEIGHT / 2;
  // Row offset below the horizon: the 9-bit row plus a sign bit.
  localparam int unsigned PW    = 10;
  localparam int unsigned DW    = PW + $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned NW    = 48;
  localparam int unsigned CW    = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned TB    = $clog2(TEX_SIZE);
  localparam int unsigned TAGW  = 1 + 10 + 9 + 6 + 6 + 4 + 1;

  // Configuration registers.
  logic [21:0] pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [6:0] cols_q, rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= 16'sd16384;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 16'sd10813;
      cols_q    <= 7'd64;
      rows_q    <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcta_pkg::RegPosX:   pos_x_q   <= cfg_data_i[21:0];
        fcta_pkg::RegPosY:   pos_y_q   <= cfg_data_i[21:0];
        fcta_pkg::RegDirX:   dir_x_q   <= cfg_data_i[15:0];
        fcta_pkg::RegDirY:   dir_y_q   <= cfg_data_i[15:0];
        fcta_pkg::RegPlaneX: plane_x_q <= cfg_data_i[15:0];
        fcta_pkg::RegPlaneY: plane_y_q <= cfg_data_i[15:0];
        fcta_pkg::RegCols:   cols_q    <= cfg_data_i[6:0];
        fcta_pkg::RegRows:   rows_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or being taken.
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: capture the beat and form the per-axis products.
  logic        v1_q;
  logic [TAGW-1:0] tag1_q;
  logic signed [31:0] px_q, py_q, sxpx_q, sxpy_q;
  logic [PW-1:0] p1_q;
  logic          horiz1;
  assign horiz1 = ({3'b000, screen_y_i} <= 12'(HalfH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag1_q <= {func_i, screen_x_i, screen_y_i, cell_col_i, cell_row_i,
                 cell_texture_i, horiz1};
      px_q   <= 32'(32'(dir_x_q - plane_x_q) * $signed(33'(SCREEN_WIDTH)));
      py_q   <= 32'(32'(dir_y_q - plane_y_q) * $signed(33'(SCREEN_WIDTH)));
      sxpx_q <= 32'($signed({1'b0, screen_x_i}) * plane_x_q) <<< 1;
      sxpy_q <= 32'($signed({1'b0, screen_x_i}) * plane_y_q) <<< 1;
      p1_q   <= PW'(screen_y_i) - PW'(HalfH);
    end
  end

  // Stage 2: numerators and the common divisor.
  logic v2_q;
  logic [TAGW-1:0] tag2_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic [DW-1:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag2_q <= tag1_q;
      nx_q   <= NW'($signed(NW'(px_q + sxpx_q)) * $signed(NW'(2 * SCREEN_HEIGHT)));
      ny_q   <= NW'($signed(NW'(py_q + sxpy_q)) * $signed(NW'(2 * SCREEN_HEIGHT)));
      // On the horizon the divisor is forced to one; the result is unused.
      den_q  <= tag1_q[0] ? DW'(1) : DW'(p1_q * DW'(SCREEN_WIDTH));
    end
  end

  // Divider lanes, one per axis; the x lane carries the tag, the y lane a
  // copy of the valid bit.
  logic signed [NW-1:0] qx, qy;
  logic [TAGW-1:0] tag3;
  logic [0:0]    lane_y_valid;

  fcta_divider #(.NW(NW), .DW(DW), .TW(TAGW)) u_div_x (
    .clk_i, .en_i(en), .num_i(nx_q), .den_i(den_q),
    .tag_i(tag2_q), .quo_o(qx), .tag_o(tag3)
  );
  fcta_divider #(.NW(NW), .DW(DW), .TW(1)) u_div_y (
    .clk_i, .en_i(en), .num_i(ny_q), .den_i(den_q),
    .tag_i(v2_q), .quo_o(qy), .tag_o(lane_y_valid)
  );

  // Valid bits travel in a reset shift line beside the divider tag.
  logic [NW:0] vline_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vline_q <= '0;
    else if (en) vline_q <= {vline_q[NW-1:0], v2_q};
  end

  // Stage 4: floor point, bounds and map read.
  logic signed [NW:0] fx, fy;
  assign fx = $signed({qx[NW-1], qx}) + $signed({1'b0, NW'(pos_x_q)});
  assign fy = $signed({qy[NW-1], qy}) + $signed({1'b0, NW'(pos_y_q)});

  logic [8:0] lim_x, lim_y;
  assign lim_x = (9'(cols_q) > 9'(MAP_SIZE)) ? 9'(MAP_SIZE) : 9'(cols_q);
  assign lim_y = (9'(rows_q) > 9'(MAP_SIZE)) ? 9'(MAP_SIZE) : 9'(rows_q);

  logic outside;
  assign outside = fx[NW] || fy[NW] ||
                   (fx[NW-1:16] >= (NW-16)'(lim_x)) ||
                   (fy[NW-1:16] >= (NW-16)'(lim_y));

  logic t_func, t_horiz;
  logic [9:0] t_sx;
  logic [8:0] t_sy;
  logic [5:0] t_col, t_row;
  logic [3:0] t_tex;
  assign {t_func, t_sx, t_sy, t_col, t_row, t_tex, t_horiz} = tag3;

  logic v4_q;
  logic [2:0] st4_q;
  logic [9:0] sx4_q;
  logic [8:0] sy4_q;
  logic [3:0] wtex4_q;
  logic [TB-1:0] u4_q, v4c_q;

  logic [3:0] cell_mem [MAP_SIZE*MAP_SIZE];
  logic [3:0] rd_q;
  logic [AW-1:0] rd_addr;
  assign rd_addr = {fy[16 +: CW], fx[16 +: CW]};

  // Map memory: writes from write beats, one registered read per pixel.
  always_ff @(posedge clk_i) begin
    if (en && vline_q[NW] && !t_func &&
        (9'(t_col) < 9'(MAP_SIZE)) && (9'(t_row) < 9'(MAP_SIZE))) begin
      cell_mem[{CW'(t_row), CW'(t_col)}] <= t_tex;
    end
    if (en) rd_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= vline_q[NW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx4_q   <= t_func ? t_sx : '0;
      sy4_q   <= t_func ? t_sy : '0;
      wtex4_q <= t_tex;
      u4_q    <= TB'((32'(fx[15:0]) * 32'(TEX_SIZE)) >> 16);
      v4c_q   <= TB'((32'(fy[15:0]) * 32'(TEX_SIZE)) >> 16);
      if (!t_func)      st4_q <= fcta_pkg::StWritten;
      else if (t_horiz) st4_q <= fcta_pkg::StHorizon;
      else if (outside) st4_q <= fcta_pkg::StOutside;
      else              st4_q <= fcta_pkg::StTexel;
    end
  end

  // Stage 5: texture check and output register.
  fcta_pkg::result_t res_d, res_q;
  always_comb begin
    res_d = '0;
    res_d.status  = st4_q;
    res_d.pixel_x = sx4_q;
    res_d.pixel_y = sy4_q;
    case (st4_q)
      fcta_pkg::StWritten: res_d.texture_number = wtex4_q;
      fcta_pkg::StTexel: begin
        res_d.texture_number = rd_q;
        if ({1'b0, rd_q} >= 5'(NUM_TEXTURES)) begin
          res_d.status = fcta_pkg::StBadTex;
        end else begin
          res_d.texel_u       = 6'(u4_q);
          res_d.texel_v       = 6'(v4c_q);
          res_d.texel_address = 12'(32'(v4c_q) * 32'(TEX_SIZE) + 32'(u4_q));
        end
      end
      default: ;
    endcase
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign pixel_x_o        = res_q.pixel_x;
  assign pixel_y_o        = res_q.pixel_y;
  assign texture_number_o = res_q.texture_number;
  assign texel_u_o        = res_q.texel_u;
  assign texel_v_o        = res_q.texel_v;
  assign texel_address_o  = res_q.texel_address;

  // Checks on pipeline control.
  `FCTA_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(res_q))
  `FCTA_ASSERT_IMP(a_lane_sync, vline_q[NW], lane_y_valid == 1'b1)
  `FCTA_ASSERT_IMP(a_stall, in_stall_o, out_valid_o && out_stall_i)
  `FCTA_ASSERT_IMP(a_write_st, out_valid_o && status_o == fcta_pkg::StWritten, pixel_x_o == '0 && texel_address_o == '0)

endmodule
`default_nettype wire

// File: design/fcta_divider.sv
// ----------------------------------------------------------------------------
// Floor cast pipelined divider
// Signed floor division of a numerator by a positive divisor, one quotient
// bit per stage, a new division can enter every cycle while en_i is high.
// ----------------------------------------------------------------------------
`default_nettype none
module fcta_divider #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 24,
  parameter int unsigned TW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic        [DW-1:0] den_i,
  input  wire logic        [TW-1:0] tag_i,
  output logic signed      [NW-1:0] quo_o,
  output logic             [TW-1:0] tag_o
);

  // Magnitude of the numerator is divided; the floor correction uses the
  // remainder at the end.
  logic [NW-1:0] mag_q [NW];
  logic [NW-1:0] quo_q [NW+1];
  logic [DW:0]   rem_q [NW+1];
  logic [DW-1:0] den_q [NW];
  logic          neg_q [NW+1];
  logic [TW-1:0] tag_q [NW+1];
  logic [DW+1:0] shifted [NW];
  logic [DW+1:0] trial   [NW];

  // Trial subtraction of every restoring step.
  always_comb begin
    for (int s = 0; s < NW; s++) begin
      shifted[s] = {rem_q[s], mag_q[s][NW-1-s]};
      trial[s]   = shifted[s] - {2'b00, den_q[s]};
    end
  end

  // Stage zero takes the operands; every later stage retires one quotient bit.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0] <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      quo_q[0] <= '0;
      rem_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[NW-1];
      tag_q[0] <= tag_i;
      for (int s = 0; s < NW - 1; s++) begin
        mag_q[s+1] <= mag_q[s];
        den_q[s+1] <= den_q[s];
      end
      for (int s = 0; s < NW; s++) begin
        neg_q[s+1] <= neg_q[s];
        tag_q[s+1] <= tag_q[s];
        if (!trial[s][DW+1]) begin
          rem_q[s+1] <= trial[s][DW:0];
          quo_q[s+1] <= quo_q[s] | (NW'(1) << (NW-1-s));
        end else begin
          rem_q[s+1] <= shifted[s][DW:0];
          quo_q[s+1] <= quo_q[s];
        end
      end
    end
  end

  // Sign and floor correction.
  always_comb begin
    if (neg_q[NW]) begin
      quo_o = -$signed(quo_q[NW]) - ((rem_q[NW] != '0) ? NW'(1) : NW'(0));
    end else begin
      quo_o = $signed(quo_q[NW]);
    end
  end
  assign tag_o = tag_q[NW];

endmodule
`default_nettype wire

// File: sim/floor_cast_texel_address_tb.sv
// ----------------------------------------------------------------------------
// Floor cast texel address testbench
// Self-checking bench: fills the reachable part of the cell map, then streams
// directed and random map writes and pixel beats through several camera
// settings. Every result beat is compared field by field against an in-bench
// fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module floor_cast_texel_address_tb;

  localparam int unsigned ScrW    = 640;
  localparam int unsigned ScrH    = 480;
  localparam int unsigned MapDim  = 64;
  localparam int unsigned TexDim  = 64;
  localparam int unsigned NumTex  = 8;
  localparam int unsigned FillDim = 16;
  localparam int unsigned Drain   = 150;
  localparam longint      CycleLimit = 3000000;

  // One input beat.
  typedef struct {
    bit       func;
    bit [9:0] sx;
    bit [8:0] sy;
    bit [5:0] col;
    bit [5:0] row;
    bit [3:0] tex;
  } beat_t;

  // Predicts every result beat and holds it until the block delivers it.
  class texel_scoreboard;
    bit [21:0] pos_x, pos_y;
    bit [15:0] dir_x, dir_y, plane_x, plane_y;
    bit [6:0]  cols, rows;
    bit [3:0]  cell_map [MapDim*MapDim];
    fcta_pkg::result_t expected_q [$];
    int        errors;
    int        checked;
    int        texels;

    function new();
      pos_x = 0; pos_y = 0; dir_x = 16384; dir_y = 0;
      plane_x = 0; plane_y = 10813; cols = 64; rows = 64;
      errors = 0; checked = 0; texels = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] val);
      case (idx)
        fcta_pkg::RegPosX:   pos_x = val[21:0];
        fcta_pkg::RegPosY:   pos_y = val[21:0];
        fcta_pkg::RegDirX:   dir_x = val[15:0];
        fcta_pkg::RegDirY:   dir_y = val[15:0];
        fcta_pkg::RegPlaneX: plane_x = val[15:0];
        fcta_pkg::RegPlaneY: plane_y = val[15:0];
        fcta_pkg::RegCols:   cols = val[6:0];
        default:             rows = val[6:0];
      endcase
    endfunction

    // Q16 floor offset along one axis, rounded toward minus infinity.
    function longint floor_offset(bit [15:0] d, bit [15:0] pl, longint sx, longint p);
      longint dv, pv, num, den, q;
      dv = longint'($signed(d));
      pv = longint'($signed(pl));
      num = longint'(ScrH) * ((dv - pv) * ScrW + 2 * pv * sx) * 2;
      den = p * ScrW;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
    endfunction

    function void note_input(beat_t b);
      fcta_pkg::result_t r;
      longint p, fx, fy, cx, cy, lim_x, lim_y;
      bit [15:0] frx, fry;
      r = '0;
      if (!b.func) begin
        cell_map[b.row*MapDim + b.col] = b.tex;
        r.status = fcta_pkg::StWritten;
        r.texture_number = b.tex;
      end else begin
        r.pixel_x = b.sx;
        r.pixel_y = b.sy;
        if (b.sy <= ScrH/2) begin
          r.status = fcta_pkg::StHorizon;
        end else begin
          p = longint'(b.sy) - ScrH/2;
          fx = longint'(pos_x) + floor_offset(dir_x, plane_x, longint'(b.sx), p);
          fy = longint'(pos_y) + floor_offset(dir_y, plane_y, longint'(b.sx), p);
          lim_x = (cols > MapDim) ? MapDim : cols;
          lim_y = (rows > MapDim) ? MapDim : rows;
          cx = fx >>> 16;
          cy = fy >>> 16;
          if (fx < 0 || fy < 0 || cx >= lim_x || cy >= lim_y) begin
            r.status = fcta_pkg::StOutside;
          end else begin
            r.texture_number = cell_map[cy*MapDim + cx];
            if (r.texture_number >= NumTex) begin
              r.status = fcta_pkg::StBadTex;
            end else begin
              frx = fx[15:0];
              fry = fy[15:0];
              r.status = fcta_pkg::StTexel;
              r.texel_u = (32'(frx) * TexDim) >> 16;
              r.texel_v = (32'(fry) * TexDim) >> 16;
              r.texel_address = r.texel_v * TexDim + r.texel_u;
              texels++;
            end
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(fcta_pkg::result_t got);
      fcta_pkg::result_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.status != e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.pixel_x != e.pixel_x) begin
        $error("pixel_x expected %0d actual %0d", e.pixel_x, got.pixel_x); errors++;
      end
      if (got.pixel_y != e.pixel_y) begin
        $error("pixel_y expected %0d actual %0d", e.pixel_y, got.pixel_y); errors++;
      end
      if (got.texture_number != e.texture_number) begin
        $error("texture_number expected %0d actual %0d", e.texture_number,
               got.texture_number);
        errors++;
      end
      if (got.texel_u != e.texel_u) begin
        $error("texel_u expected %0d actual %0d", e.texel_u, got.texel_u); errors++;
      end
      if (got.texel_v != e.texel_v) begin
        $error("texel_v expected %0d actual %0d", e.texel_v, got.texel_v); errors++;
      end
      if (got.texel_address != e.texel_address) begin
        $error("texel_address expected %0d actual %0d", e.texel_address,
               got.texel_address);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [9:0]  screen_x_i = '0;
  logic [8:0]  screen_y_i = '0;
  logic [5:0]  cell_col_i = '0;
  logic [5:0]  cell_row_i = '0;
  logic [3:0]  cell_texture_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [9:0]  pixel_x_o;
  logic [8:0]  pixel_y_o;
  logic [3:0]  texture_number_o;
  logic [5:0]  texel_u_o;
  logic [5:0]  texel_v_o;
  logic [11:0] texel_address_o;

  texel_scoreboard sb = new();
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycles = 0;
  int     beats_sent = 0;

  floor_cast_texel_address dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Inputs move only at rising edges, so the falling edge sees stable values.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({status_o, pixel_x_o, pixel_y_o, texture_number_o,
                       texel_u_o, texel_v_o, texel_address_o});
    end
  end

  task automatic send_beat(beat_t b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= b.func;
    screen_x_i     <= b.sx;
    screen_y_i     <= b.sy;
    cell_col_i     <= b.col;
    cell_row_i     <= b.row;
    cell_texture_i <= b.tex;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_input(b);
    beats_sent++;
  endtask

  task automatic map_write(int col, int row, int tex);
    beat_t b;
    b = '{func: 1'b0, sx: 10'($urandom), sy: 9'($urandom), col: col[5:0],
          row: row[5:0], tex: tex[3:0]};
    send_beat(b);
  endtask

  task automatic pixel(int sx, int sy);
    beat_t b;
    b = '{func: 1'b1, sx: sx[9:0], sy: sy[8:0], col: 6'($urandom),
          row: 6'($urandom), tex: 4'($urandom)};
    send_beat(b);
  endtask

  // Lets the pipeline empty before registers change.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // Leaves the write channel valid; the caller drops it after the last write.
  task automatic reg_write(logic [2:0] idx, bit [31:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    sb.set_reg(idx, val);
  endtask

  task automatic set_camera(bit [31:0] px, bit [31:0] py, bit [31:0] dx, bit [31:0] dy,
                            bit [31:0] plx, bit [31:0] ply, bit [31:0] nc, bit [31:0] nr);
    wait_drained();
    reg_write(fcta_pkg::RegPosX, px);
    reg_write(fcta_pkg::RegPosY, py);
    reg_write(fcta_pkg::RegDirX, dx);
    reg_write(fcta_pkg::RegDirY, dy);
    reg_write(fcta_pkg::RegPlaneX, plx);
    reg_write(fcta_pkg::RegPlaneY, ply);
    reg_write(fcta_pkg::RegCols, nc);
    reg_write(fcta_pkg::RegRows, nr);
    cfg_valid_i <= 1'b0;
  endtask

  // Map limits keep every reachable cell inside the filled area: either a
  // map no larger than the filled square or a single wide row that may exceed the map size.
  // Camera mostly inside that square with modest vectors, so rays land inside.
  task automatic random_camera();
    bit [31:0] nc, nr;
    if ($urandom_range(4) == 0) begin
      nc = $urandom_range(127);
      nr = $urandom_range(1);
    end else begin
      nc = $urandom_range(FillDim);
      nr = $urandom_range(FillDim);
    end
    if ($urandom_range(3) == 0) begin
      set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, nc, nr);
    end else begin
      set_camera($urandom_range(14 << 16, 0), $urandom_range(14 << 16, 0),
                 $urandom_range(32767) - 16384, $urandom_range(32767) - 16384,
                 $urandom_range(32767) - 16384, $urandom_range(32767) - 16384, nc, nr);
    end
  endtask

  task automatic random_beats(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        map_write($urandom_range(63), $urandom_range(63),
                  ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(7));
      end else if ($urandom_range(99) < 15) begin
        pixel($urandom_range(1023), $urandom_range(240));
      end else begin
        pixel($urandom_range(1023), $urandom_range(511, 241));
      end
      // When the sender idles, it holds off once until the pipeline is empty.
      if (i == count / 2 && send_idle_pct != 0) wait_drained();
    end
  endtask

  initial begin
    bit ok;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every cell that a pixel can reach gets a texture first: the low square
    // corner of the map and the whole first row.
    for (int r = 0; r < FillDim; r++) begin
      for (int c = 0; c < FillDim; c++) map_write(c, r, (r * 7 + c) % 16);
    end
    for (int c = FillDim; c < MapDim; c++) map_write(c, 0, (c * 5) % 16);

    // Directed: horizon, first row below it, screen edges, field extremes.
    pixel(0, 0);
    pixel(1023, 240);
    pixel(320, 241);
    pixel(0, 511);
    pixel(1023, 479);
    pixel(639, 300);
    map_write(63, 63, 15);
    map_write(0, 0, 0);
    set_camera(8 << 16, 8 << 16, 16384, 0, 0, 10813, FillDim, FillDim);
    map_write(8, 8, 9);
    map_write(9, 8, 3);
    pixel(320, 479);
    pixel(320, 241);
    pixel(0, 400);
    pixel(1023, 511);
    pixel(100, 260);
    set_camera(32'h3FFFFF, 32'h3FFFFF, 32'h8000, 32'h7FFF, 32'h7FFF, 32'h8000, 0, 127);
    pixel(320, 479);
    pixel(0, 241);
    pixel(1023, 511);
    set_camera(0, 0, 32'h7FFF, 32'h7FFF, 32'h8000, 32'h7FFF, 1, 1);
    pixel(0, 241);
    pixel(1023, 300);
    pixel(512, 511);

    // Random phases under three idling patterns.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 65 : 0;
      recv_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 37 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        random_camera();
        random_beats(80);
      end
    end

    send_idle_pct = 0;
    wait_drained();
    recv_idle_pct = 0;
    ok = (sb.errors == 0) && (sb.expected_q.size() == 0);
    $display("Sent %0d beats, checked %0d results, %0d of them floor texels.",
             beats_sent, sb.checked, sb.texels);
    if (ok) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
